[rtl/pbbg_pkg.sv]
// shared types and codes for the pair bandwidth budget gate
package pbbg_pkg;

    // item functions
    localparam logic [1:0] FUNC_REQUEST = 2'd0;
    localparam logic [1:0] FUNC_LOAD    = 2'd1;
    localparam logic [1:0] FUNC_RELOAD  = 2'd2;
    localparam logic [1:0] FUNC_TICK    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_RECONF   = 3'd1;
    localparam logic [2:0] ST_NO_ALLOC = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // config port: byte address width and register select (paddr[2])
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SEL_INTERVAL = 1'b0;
    localparam logic REG_SEL_DELAY    = 1'b1;

    localparam logic [15:0] INTERVAL_RESET = 16'd1;
    localparam logic [15:0] DELAY_RESET    = 16'd0;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  src_node;
        logic [3:0]  dst_node;
        logic [31:0] amount;
    } t_in_beat;

    typedef struct packed {
        logic       granted;
        logic [2:0] status;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] decision_interval;
        logic [15:0] reconfig_delay;
    } t_cfg;

endpackage

[rtl/pbbg_ram.sv]
// simple dual-port synchronous ram with registered read
module pbbg_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pbbg_apb_regs.sv]
// apb configuration registers: decision interval and reconfiguration delay
module pbbg_apb_regs
    import pbbg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // word-addressed: only paddr[2] selects
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decision_interval <= INTERVAL_RESET;
            r_cfg.reconfig_delay    <= DELAY_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SEL_INTERVAL: r_cfg.decision_interval <= pwdata[15:0];
                REG_SEL_DELAY:    r_cfg.reconfig_delay    <= pwdata[15:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEL_INTERVAL: prdata = {16'd0, r_cfg.decision_interval};
            REG_SEL_DELAY:    prdata = {16'd0, r_cfg.reconfig_delay};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/pair_bandwidth_budget_gate.sv]
// pair bandwidth budget gate: per source-destination byte credit check
// The gate keeps two tables of NODES*NODES entries, each a {valid, bytes}
// word in a one-port-read one-port-write synchronous ram: the allocation
// table, filled by load beats, and the budget table, charged by packet
// requests. One input beat gives exactly one result beat. For a request, a load
// or a tick the budget ram is read in the accept cycle; the entry is checked,
// charged and written back in the exec state once the output register is free
// or draining, so one item is in flight at a time. A reload passes the accept
// cycle, a sweep of the allocation ram at one entry per cycle with each valid
// entry copied into the budget ram in the cycle after its read, and an exec state
// that writes the last entry and retires the beat. After reset both rams are
// cleared in a pass over every entry, during which no input beat is taken; apb
// writes are accepted at any time. A finished result sits in the output
// register while the next beat is accepted; the block stalls only when a second
// result is ready before the first was taken.
module pair_bandwidth_budget_gate
    import pbbg_pkg::*;
#(
    parameter int NODES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int PAIRS = NODES * NODES;
    localparam int IDX_W = $clog2(PAIRS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAIRS - 1);

    // sequencer states
    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;
    localparam logic [1:0] S_RELOAD = 2'd3;

    t_cfg             w_cfg;
    logic [1:0]       r_state, n_state;
    t_in_beat         r_item;
    logic [IDX_W-1:0] r_idx;
    logic             r_in_range;
    logic [IDX_W-1:0] r_cnt;
    logic             r_wb_pend;
    logic [IDX_W-1:0] r_wb_idx;
    logic [16:0]      r_phase;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic             w_accept;
    logic             w_fire;
    logic [31:0]      w_idx_full;
    logic [IDX_W-1:0] w_in_idx;
    logic             w_in_range;
    logic [16:0]      w_period;
    logic [16:0]      w_phase_inc;
    logic [2:0]       w_req_status;
    t_out_beat        w_result;

    // ram ports
    logic             w_bud_we;
    logic [IDX_W-1:0] w_bud_waddr;
    logic [32:0]      w_bud_wdata;
    logic [IDX_W-1:0] w_bud_raddr;
    logic [32:0]      w_bud_rdata;
    logic             w_alc_we;
    logic [IDX_W-1:0] w_alc_waddr;
    logic [32:0]      w_alc_wdata;
    logic [32:0]      w_alc_rdata;

    pbbg_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // allocation table, {valid, bytes}
    pbbg_ram #(.DEPTH(PAIRS), .WIDTH(33)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (w_alc_we),
        .i_waddr (w_alc_waddr),
        .i_wdata (w_alc_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_alc_rdata)
    );

    // budget table, {valid, bytes}
    pbbg_ram #(.DEPTH(PAIRS), .WIDTH(33)) u_budget_ram (
        .i_clk   (i_clk),
        .i_we    (w_bud_we),
        .i_waddr (w_bud_waddr),
        .i_wdata (w_bud_wdata),
        .i_raddr (w_bud_raddr),
        .o_rdata (w_bud_rdata)
    );

    // handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // exec may retire only when the output register is free or draining
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // pair index = src * NODES + dst
    assign w_idx_full = 32'(i_in_data.src_node) * 32'(NODES) + 32'(i_in_data.dst_node);
    assign w_in_idx   = w_idx_full[IDX_W-1:0];
    assign w_in_range = (32'(i_in_data.src_node) < 32'(NODES))
                     && (32'(i_in_data.dst_node) < 32'(NODES));

    // budget read: new beat's pair while idle, held pair while executing
    assign w_bud_raddr = (r_state == S_IDLE) ? w_in_idx : r_idx;

    // phase period, 17 bits so the sum never wraps
    assign w_period    = 17'(w_cfg.decision_interval) + 17'(w_cfg.reconfig_delay);
    assign w_phase_inc = r_phase + 17'd1;

    // request check against the entry read last cycle
    always_comb begin
        priority if (r_phase < {1'b0, w_cfg.reconfig_delay}) begin
            w_req_status = ST_RECONF;
        end else if (!r_in_range || !w_bud_rdata[32]) begin
            w_req_status = ST_NO_ALLOC;
        end else if (w_bud_rdata[31:0] < r_item.amount) begin
            w_req_status = ST_SHORT;
        end else begin
            w_req_status = ST_GRANTED;
        end
    end

    always_comb begin
        if (r_item.func == FUNC_REQUEST) begin
            w_result.status  = w_req_status;
            w_result.granted = (w_req_status == ST_GRANTED);
        end else begin
            w_result.status  = ST_DONE;
            w_result.granted = 1'b0;
        end
    end

    // budget write: clearing pass, reload copy, or charge on grant
    always_comb begin
        w_bud_we    = 1'b0;
        w_bud_waddr = r_idx;
        w_bud_wdata = {1'b1, w_bud_rdata[31:0] - r_item.amount};
        priority if (r_state == S_CLEAR) begin
            w_bud_we    = 1'b1;
            w_bud_waddr = r_cnt;
            w_bud_wdata = 33'd0;
        end else if (r_wb_pend) begin
            // copy only entries whose allocation is valid
            w_bud_we    = w_alc_rdata[32];
            w_bud_waddr = r_wb_idx;
            w_bud_wdata = w_alc_rdata;
        end else if (w_fire && w_result.granted) begin
            w_bud_we = 1'b1;
        end else begin
            w_bud_we = 1'b0;
        end
    end

    // allocation write: clearing pass or in-range load
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_alc_we    = 1'b1;
            w_alc_waddr = r_cnt;
            w_alc_wdata = 33'd0;
        end else begin
            w_alc_we    = w_fire && (r_item.func == FUNC_LOAD) && r_in_range;
            w_alc_waddr = r_idx;
            w_alc_wdata = {1'b1, r_item.amount};
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.func == FUNC_RELOAD) ? S_RELOAD : S_EXEC;
                end
            end
            S_RELOAD: begin
                if (r_cnt == LAST_IDX) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_fire) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_wb_pend   <= 1'b0;
            r_phase     <= 17'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            // sweep counter shared by the clearing pass and reload
            if ((r_state == S_CLEAR) || (r_state == S_RELOAD)) begin
                r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + IDX_W'(1);
            end
            r_wb_pend <= (r_state == S_RELOAD);
            if (w_fire && (r_item.func == FUNC_TICK)) begin
                r_phase <= (w_phase_inc >= w_period) ? 17'd0 : w_phase_inc;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item     <= i_in_data;
            r_idx      <= w_in_idx;
            r_in_range <= w_in_range;
        end
        r_wb_idx <= r_cnt;
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted beat always goes to work, never back to idle or clear
    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC) || (r_state == S_RELOAD))
        else $error("accepted beat did not start execution");

    // the grant flag and the status code agree
    a_grant_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.granted == (o_out_data.status == ST_GRANTED)))
        else $error("grant flag disagrees with status");

    // a tick steps the phase by one or wraps it to zero
    a_tick_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_item.func == FUNC_TICK))
            |=> (r_phase == 17'd0) || (r_phase == $past(r_phase) + 17'd1))
        else $error("phase step on tick is wrong");

    // budget is never charged during the reconfiguration window
    a_no_charge_reconf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_item.func == FUNC_REQUEST)
            && (r_phase < {1'b0, w_cfg.reconfig_delay})) |-> !w_bud_we)
        else $error("budget written during reconfiguration");

endmodule
